[sv/bamf_pkg.sv]
// Shared types, widths and constants for the border-aware 3x3 mean filter.
// Pure package; no dependencies.
package bamf_pkg;

    localparam int PIX_W          = 8;
    localparam int SUM_W          = 12;
    localparam int RECIP_W        = 17;
    localparam int RECIP_SHIFT    = 16;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 9;
    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;

    localparam logic [CFG_DATA_W-1:0] DIM_RESET = 9'd256;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    // floor(sum / (rows * cols)) == (sum * recip) >> RECIP_SHIFT for sum <= 9 * 255
    function automatic logic [RECIP_W-1:0] mean_recip(input logic [1:0] rows,
                                                      input logic [1:0] cols);
        logic [3:0]         cnt;
        logic [RECIP_W-1:0] r;
        cnt = 4'(rows) * 4'(cols);
        unique case (cnt)
            4'd1:    r = 17'd65536;
            4'd2:    r = 17'd32768;
            4'd3:    r = 17'd21846;
            4'd4:    r = 17'd16384;
            4'd6:    r = 17'd10923;
            4'd9:    r = 17'd7282;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

[sv/bamf_line_store.sv]
// Two line stores (older and newer row) with registered read and a bypass
// for a write to the column being read in the same cycle. Uses bamf_pkg.
module bamf_line_store #(
    parameter int MAX_WIDTH = bamf_pkg::MAX_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              rd_en,
    input  logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] rd_addr,
    input  logic                              wr_en,
    input  logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] wr_addr,
    input  logic [bamf_pkg::PIX_W-1:0]        wr_pix,
    output logic [bamf_pkg::PIX_W-1:0]        older_q,
    output logic [bamf_pkg::PIX_W-1:0]        newer_q
);
    import bamf_pkg::*;

    logic [PIX_W-1:0] older_row_store [MAX_WIDTH];
    logic [PIX_W-1:0] newer_row_store [MAX_WIDTH];

    logic [PIX_W-1:0] rd_older_reg;
    logic [PIX_W-1:0] rd_newer_reg;
    logic [PIX_W-1:0] byp_older_reg;
    logic [PIX_W-1:0] byp_newer_reg;
    logic             byp_reg;
    logic             byp_next;

    assign older_q  = byp_reg ? byp_older_reg : rd_older_reg;
    assign newer_q  = byp_reg ? byp_newer_reg : rd_newer_reg;
    assign byp_next = rd_en ? (wr_en && (wr_addr == rd_addr)) : byp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_reg <= 1'b0;
        end
        else
        begin
            byp_reg <= byp_next;
        end
    end

    // older takes the newer row's old word, newer takes the incoming pixel
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            older_row_store[wr_addr] <= newer_q;
            newer_row_store[wr_addr] <= wr_pix;
        end
        if (rd_en)
        begin
            rd_older_reg  <= older_row_store[rd_addr];
            rd_newer_reg  <= newer_row_store[rd_addr];
            byp_older_reg <= newer_q;
            byp_newer_reg <= wr_pix;
        end
    end

endmodule

[sv/border_aware_3x3_mean_filter.sv]
// Top level of the border-aware 3x3 mean filter: frame counters, window,
// neighbourhood sum and reciprocal divide. Uses bamf_pkg and bamf_line_store.
//
//  channel | direction | handshake           | word
//  --------+-----------+---------------------+--------------------------------
//  in      | input     | in_valid / in_stall | pixel_value, flush
//  out     | output    | out_valid/out_stall | smoothed_value, frame_last
//  cfg     | input     | cfg_we              | cfg_index, cfg_data
//
// One word per clock is taken while in_stall is low; a result leaves once the word
// that produces it passes line store read, window and sum, reciprocal multiply.
// Each of the three stages holds only while its successor is full and stalled.
// Reset gives a 256x256 frame and an empty pipeline; line stores are not cleared.
// A write to a known register restarts the frame.
module border_aware_3x3_mean_filter #(
    parameter int MAX_WIDTH  = bamf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bamf_pkg::MAX_HEIGHT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [bamf_pkg::PIX_W-1:0]      pixel_value,
    input  logic                            flush,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [bamf_pkg::PIX_W-1:0]      smoothed_value,
    output logic                            frame_last,
    input  logic                            cfg_we,
    input  logic [bamf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bamf_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bamf_pkg::*;

    localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int ROWC_W = $clog2(MAX_HEIGHT + 2);
    localparam int PROD_W = SUM_W + RECIP_W;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [PIX_W-1:0] pix;
        logic             produce;
        logic             last;
        logic             left_ok;
        logic             right_ok;
        logic             top_ok;
        logic             bot_ok;
    } s1_item_t;

    // configuration
    logic [CFG_DATA_W-1:0] width_reg, width_next;
    logic [CFG_DATA_W-1:0] height_reg, height_next;
    logic                  restart;
    logic [COL_W-1:0]      wm1;
    logic [ROW_W-1:0]      hm1;

    // frame counters
    logic [COL_W-1:0]  in_col_reg, in_col_next;
    logic [ROWC_W-1:0] in_row_reg, in_row_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;
    logic [ROW_W-1:0]  out_row_reg, out_row_next;
    logic              draining_reg, draining_next;
    logic              out_on_reg, out_on_next;

    logic             accept;
    logic             take;
    logic             col_wrap;
    logic             frame_end;
    s1_item_t         s1_in;

    // pipeline
    logic             s1_v_reg, s1_v_next;
    s1_item_t         s1_reg;
    logic             s2_v_reg, s2_v_next;
    logic [SUM_W-1:0] s2_sum_reg;
    logic [RECIP_W-1:0] s2_recip_reg;
    logic             s2_last_reg;
    logic             out_v_reg, out_v_next;
    logic [PIX_W-1:0] out_pix_reg;
    logic             out_last_reg;

    logic             o_ready;
    logic             s2_ready;
    logic             s2_adv;
    logic             s1_adv;

    logic [PIX_W-1:0] older_q;
    logic [PIX_W-1:0] newer_q;
    logic [PIX_W-1:0] window_reg  [3][3];
    logic [PIX_W-1:0] window_next [3][3];
    logic [PIX_W-1:0] incoming    [3];
    logic             row_ok      [3];
    logic [SUM_W-1:0] sum;
    logic [1:0]       rows_n;
    logic [1:0]       cols_n;
    logic [PROD_W-1:0] prod;

    // clamped dimensions, minus one
    always_comb
    begin
        if (width_reg == '0)
            wm1 = '0;
        else if (32'(width_reg) > MAX_WIDTH)
            wm1 = COL_W'(MAX_WIDTH - 1);
        else
            wm1 = COL_W'(width_reg - 1'b1);
        if (height_reg == '0)
            hm1 = '0;
        else if (32'(height_reg) > MAX_HEIGHT)
            hm1 = ROW_W'(MAX_HEIGHT - 1);
        else
            hm1 = ROW_W'(height_reg - 1'b1);
    end

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        restart     = 1'b0;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:
                begin
                    width_next = cfg_data;
                    restart    = 1'b1;
                end
                REG_FRAME_HEIGHT:
                begin
                    height_next = cfg_data;
                    restart     = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // handshake and stage advance
    assign o_ready  = !out_v_reg || !out_stall;
    assign s2_ready = !s2_v_reg || o_ready;
    assign s2_adv   = s2_v_reg && o_ready;
    assign s1_adv   = s1_v_reg && (!s1_reg.produce || s2_ready);
    assign in_stall = s1_v_reg && !s1_adv;
    assign accept   = in_valid && !in_stall;
    assign take     = accept && (draining_reg || !flush);

    assign col_wrap  = (in_col_reg == wm1);
    assign frame_end = out_on_reg && (out_row_reg == hm1) && (out_col_reg == wm1);

    always_comb
    begin
        s1_in.col      = in_col_reg;
        s1_in.pix      = draining_reg ? '0 : pixel_value;
        s1_in.produce  = out_on_reg;
        s1_in.last     = frame_end;
        s1_in.left_ok  = (out_col_reg != '0);
        s1_in.right_ok = (out_col_reg != wm1);
        s1_in.top_ok   = (out_row_reg != '0);
        s1_in.bot_ok   = (out_row_reg != hm1);
    end

    always_comb
    begin
        in_col_next   = in_col_reg;
        in_row_next   = in_row_reg;
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        draining_next = draining_reg;
        out_on_next   = out_on_reg;
        if (restart)
        begin
            in_col_next   = '0;
            in_row_next   = '0;
            out_col_next  = '0;
            out_row_next  = '0;
            draining_next = 1'b0;
            out_on_next   = 1'b0;
        end
        else if (take)
        begin
            in_col_next = col_wrap ? '0 : in_col_reg + COL_W'(1);
            if (col_wrap)
                in_row_next = in_row_reg + ROWC_W'(1);
            if (!draining_reg && col_wrap && (in_row_reg == ROWC_W'(hm1)))
                draining_next = 1'b1;
            // first output comes one row plus one pixel behind the input
            if ((in_row_reg == ROWC_W'(1)) && (in_col_reg == '0))
                out_on_next = 1'b1;
            if (frame_end)
            begin
                in_col_next   = '0;
                in_row_next   = '0;
                out_col_next  = '0;
                out_row_next  = '0;
                draining_next = 1'b0;
                out_on_next   = 1'b0;
            end
            else if (out_on_reg)
            begin
                if (out_col_reg == wm1)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + ROW_W'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + COL_W'(1);
                end
            end
        end
    end

    bamf_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (take),
        .rd_addr (in_col_reg),
        .wr_en   (s1_adv),
        .wr_addr (s1_reg.col),
        .wr_pix  (s1_reg.pix),
        .older_q (older_q),
        .newer_q (newer_q)
    );

    // window shift and in-frame sum; right-edge outputs use the same columns
    assign incoming[0] = older_q;
    assign incoming[1] = newer_q;
    assign incoming[2] = s1_reg.pix;
    assign row_ok[0]   = s1_reg.top_ok;
    assign row_ok[1]   = 1'b1;
    assign row_ok[2]   = s1_reg.bot_ok;

    always_comb
    begin
        sum = '0;
        for (int r = 0; r < 3; r++)
        begin
            window_next[r][0] = window_reg[r][1];
            window_next[r][1] = window_reg[r][2];
            window_next[r][2] = incoming[r];
            if (row_ok[r])
            begin
                if (s1_reg.left_ok)
                    sum = sum + SUM_W'(window_next[r][0]);
                sum = sum + SUM_W'(window_next[r][1]);
                if (s1_reg.right_ok)
                    sum = sum + SUM_W'(window_next[r][2]);
            end
        end
    end

    assign rows_n = 2'd1 + 2'(s1_reg.top_ok) + 2'(s1_reg.bot_ok);
    assign cols_n = 2'd1 + 2'(s1_reg.left_ok) + 2'(s1_reg.right_ok);
    assign prod   = PROD_W'(s2_sum_reg) * PROD_W'(s2_recip_reg);

    always_comb
    begin
        s1_v_next = s1_v_reg;
        if (take)
            s1_v_next = 1'b1;
        else if (s1_adv)
            s1_v_next = 1'b0;
        s2_v_next = s2_v_reg;
        if (s1_adv && s1_reg.produce)
            s2_v_next = 1'b1;
        else if (s2_adv)
            s2_v_next = 1'b0;
        out_v_next = out_v_reg;
        if (s2_adv)
            out_v_next = 1'b1;
        else if (o_ready)
            out_v_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= DIM_RESET;
            height_reg   <= DIM_RESET;
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            draining_reg <= 1'b0;
            out_on_reg   <= 1'b0;
            s1_v_reg     <= 1'b0;
            s2_v_reg     <= 1'b0;
            out_v_reg    <= 1'b0;
        end
        else
        begin
            width_reg    <= width_next;
            height_reg   <= height_next;
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            draining_reg <= draining_next;
            out_on_reg   <= out_on_next;
            s1_v_reg     <= s1_v_next;
            s2_v_reg     <= s2_v_next;
            out_v_reg    <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            s1_reg <= s1_in;
        if (s1_adv)
            window_reg <= window_next;
        if (s1_adv && s1_reg.produce)
        begin
            s2_sum_reg   <= sum;
            s2_recip_reg <= mean_recip(rows_n, cols_n);
            s2_last_reg  <= s1_reg.last;
        end
        if (s2_adv)
        begin
            out_pix_reg  <= prod[RECIP_SHIFT +: PIX_W];
            out_last_reg <= s2_last_reg;
        end
    end

    assign out_valid      = out_v_reg;
    assign smoothed_value = out_pix_reg;
    assign frame_last     = out_last_reg;

    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_v_reg && !s1_adv |=> s1_v_reg && $stable(s1_reg))
        else $error("window stage word dropped while blocked");

    a_in_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        in_col_reg <= wm1)
        else $error("input column beyond frame width");

    a_out_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_row_reg <= hm1)
        else $error("output row beyond frame height");

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        take && frame_end |=> in_col_reg == '0 && !draining_reg && !out_on_reg)
        else $error("frame did not restart after its last output");

endmodule
